// ===== rtl/core/cpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page allocator package
// Field widths, status codes, request kinds and controller states shared by
// the allocator core, its divider and its port checker.
// ----------------------------------------------------------------------------
package cpa_pkg;

    // Field widths of the request and result items.
    localparam int SIZE_W     = 19;
    localparam int ADDR_W     = 18;
    localparam int STAT_W     = 2;
    localparam int CFG_W      = 7;
    localparam int QUOT_W     = 20;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Page count after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Request kinds carried in tuser.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_RUN   = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_ADDR = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_MARK,
        S_RESULT
    } t_state;

endpackage

// ===== rtl/core/cpa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page index divider
// Divides by a fixed page size with a reciprocal multiply. The dividend is
// registered on the start pulse and the product the cycle after; the
// registered quotient is ready while o_done is high.
// ----------------------------------------------------------------------------
module cpa_div #(
    parameter int DIVISOR = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cpa_pkg::QUOT_W-1:0]  i_dividend,
    output logic                        o_done,
    output logic [cpa_pkg::QUOT_W-1:0]  o_quotient
);

    localparam int DW  = cpa_pkg::QUOT_W;
    localparam int LW  = $clog2(DIVISOR);
    localparam int SH  = DW + LW;
    localparam int KW  = DW + 2;
    localparam int PRW = DW + KW;

    // Rounded-up reciprocal; exact floor division for every DW-bit dividend.
    localparam logic [63:0]   SCALE = 64'd1 << SH;
    localparam logic [63:0]   RECIP = (SCALE + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [KW-1:0] MULT  = RECIP[KW-1:0];

    logic [DW-1:0]  r_dvd;
    logic [DW-1:0]  r_quot;
    logic           r_busy;
    logic           r_done;
    logic [PRW-1:0] w_prod;

    // Scaled product; the quotient sits above the scale shift.
    assign w_prod = PRW'(r_dvd) * PRW'(MULT);

    // Start and done pulses.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // Dividend and quotient registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
        end
        if (r_busy) begin
            r_quot <= DW'(w_prod[PRW-1:SH]);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

// ===== rtl/core/contiguous_page_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page allocator
// First-fit allocator over a one-bit-per-page map held in a synchronous RAM.
// Zero-size allocates go straight to the result; frees and oversize
// allocates finish after the page index divider; other allocates then scan the
// map, paced by its single read port, and mark the found run page by page.
// One item is in work at a time; the next is taken the cycle after the result.
// Reset is synchronous; afterwards a clearing pass frees every page in turn
// while no item is accepted.
// ----------------------------------------------------------------------------
module contiguous_page_allocator_top #(
    parameter int PAGES      = 64,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration: page count.
    input  logic                            i_cfg_we,
    input  logic [cpa_pkg::CFG_W-1:0]       i_cfg_wdata,
    // Request items.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: size_bytes[18:0], address[36:19], zero pad [39:37].
    input  logic [cpa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: kind.
    input  logic                            s_axis_tuser,
    // Result items.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: status[1:0], run_start[19:2], zero pad [23:20].
    output logic [cpa_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int IW  = $clog2(PAGES);
    localparam int CW  = $clog2(PAGES + 1);
    localparam int MW  = (CW > cpa_pkg::CFG_W) ? CW : cpa_pkg::CFG_W;
    localparam int PBW = $clog2(PAGE_BYTES + 1);
    localparam int PW  = IW + PBW + cpa_pkg::ADDR_W;
    localparam int DW  = cpa_pkg::QUOT_W;

    cpa_pkg::t_state  r_state, n_state;
    logic [cpa_pkg::CFG_W-1:0] r_pages;
    logic             r_kind, n_kind;
    logic [CW-1:0]    r_clr, n_clr;
    logic [CW-1:0]    r_need, n_need;
    logic [CW-1:0]    r_ra, n_ra;
    logic [CW-1:0]    r_di, n_di;
    logic [CW-1:0]    r_run, n_run;
    logic             r_dv, n_dv;
    logic [IW-1:0]    r_wa, n_wa;
    logic [IW-1:0]    r_last, n_last;
    logic [IW-1:0]    r_first, n_first;
    cpa_pkg::t_status r_res_status, n_res_status;
    logic [cpa_pkg::ADDR_W-1:0] r_res_start, n_res_start;
    logic             r_out_valid;
    logic [cpa_pkg::OUT_DATA_W-1:0] r_out_data;

    // Page map memory.
    logic             r_map [PAGES];
    logic             r_rd_data;
    logic [IW-1:0]    w_rd_addr;
    logic             w_we;
    logic [IW-1:0]    w_wa;
    logic             w_wd;

    logic             w_accept;
    logic             w_load_out;
    logic [CW-1:0]    w_neff;
    logic             w_div_start;
    logic [DW-1:0]    w_dividend;
    logic             w_div_done;
    logic [DW-1:0]    w_quot;
    logic [CW-1:0]    w_run_nx;
    logic [CW-1:0]    w_first;
    logic [PW-1:0]    w_prod;

    logic [cpa_pkg::SIZE_W-1:0] w_size;
    logic [cpa_pkg::ADDR_W-1:0] w_addr;

    assign w_size   = s_axis_tdata[cpa_pkg::SIZE_W-1:0];
    assign w_addr   = s_axis_tdata[cpa_pkg::SIZE_W +: cpa_pkg::ADDR_W];
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == cpa_pkg::S_IDLE);

    // Effective page count: the register, capped at the map depth.
    assign w_neff = (MW'(r_pages) > MW'(PAGES)) ? CW'(PAGES) : CW'(r_pages);

    // Start offset of the allocated run.
    assign w_prod = PW'(r_first) * PW'(PAGE_BYTES);

    // Page index divider shared by size rounding and free lookups.
    cpa_div #(
        .DIVISOR (PAGE_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Next state and datapath control.
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_clr        = r_clr;
        n_need       = r_need;
        n_ra         = r_ra;
        n_di         = r_di;
        n_run        = r_run;
        n_dv         = r_dv;
        n_wa         = r_wa;
        n_last       = r_last;
        n_first      = r_first;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        w_we         = 1'b0;
        w_wa         = r_wa;
        w_wd         = 1'b1;
        w_rd_addr    = r_ra[IW-1:0];
        w_div_start  = 1'b0;
        w_dividend   = DW'(w_addr);
        w_load_out   = 1'b0;
        w_run_nx     = r_rd_data ? '0 : r_run + 1'b1;
        w_first      = r_di + 1'b1 - r_need;
        case (r_state)
            cpa_pkg::S_CLEAR: begin
                w_we  = 1'b1;
                w_wa  = r_clr[IW-1:0];
                w_wd  = 1'b0;
                n_clr = r_clr + 1'b1;
                if (r_clr == CW'(PAGES - 1)) begin
                    n_state = cpa_pkg::S_IDLE;
                end
            end
            cpa_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_kind      = s_axis_tuser;
                    n_res_start = '0;
                    if (s_axis_tuser == cpa_pkg::KIND_ALLOC && w_size == '0) begin
                        n_res_status = cpa_pkg::ST_BAD_SIZE;
                        n_state      = cpa_pkg::S_RESULT;
                    end else begin
                        w_div_start = 1'b1;
                        if (s_axis_tuser == cpa_pkg::KIND_ALLOC) begin
                            w_dividend = DW'(w_size) + DW'(PAGE_BYTES - 1);
                        end
                        n_state = cpa_pkg::S_DIV;
                    end
                end
            end
            cpa_pkg::S_DIV: begin
                if (w_div_done) begin
                    if (r_kind == cpa_pkg::KIND_FREE) begin
                        if (w_quot >= DW'(w_neff)) begin
                            n_res_status = cpa_pkg::ST_BAD_ADDR;
                        end else begin
                            w_we         = 1'b1;
                            w_wa         = w_quot[IW-1:0];
                            w_wd         = 1'b0;
                            n_res_status = cpa_pkg::ST_OK;
                        end
                        n_state = cpa_pkg::S_RESULT;
                    end else if (w_quot > DW'(w_neff)) begin
                        n_res_status = cpa_pkg::ST_NO_RUN;
                        n_state      = cpa_pkg::S_RESULT;
                    end else begin
                        n_need  = w_quot[CW-1:0];
                        n_ra    = '0;
                        n_dv    = 1'b0;
                        n_run   = '0;
                        n_state = cpa_pkg::S_SCAN;
                    end
                end
            end
            cpa_pkg::S_SCAN: begin
                // Issue one read per cycle; judge the page read a cycle ago.
                n_ra = r_ra + 1'b1;
                n_di = r_ra;
                n_dv = 1'b1;
                if (r_dv) begin
                    n_run = w_run_nx;
                    if (w_run_nx == r_need) begin
                        n_first = w_first[IW-1:0];
                        n_wa    = w_first[IW-1:0];
                        n_last  = r_di[IW-1:0];
                        n_state = cpa_pkg::S_MARK;
                    end else if (r_di == w_neff - 1'b1) begin
                        n_res_status = cpa_pkg::ST_NO_RUN;
                        n_state      = cpa_pkg::S_RESULT;
                    end
                end
            end
            cpa_pkg::S_MARK: begin
                // Mark the found run taken, one page per cycle.
                w_we = 1'b1;
                w_wa = r_wa;
                w_wd = 1'b1;
                n_wa = r_wa + 1'b1;
                if (r_wa == r_last) begin
                    n_res_status = cpa_pkg::ST_OK;
                    n_res_start  = w_prod[cpa_pkg::ADDR_W-1:0];
                    n_state      = cpa_pkg::S_RESULT;
                end
            end
            cpa_pkg::S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = cpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cpa_pkg::S_IDLE;
            end
        endcase
    end

    // State register and control flops.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpa_pkg::S_CLEAR;
            r_clr   <= '0;
            r_dv    <= 1'b0;
            r_pages <= cpa_pkg::CFG_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_dv    <= n_dv;
            if (i_cfg_we) begin
                r_pages <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_need       <= n_need;
        r_ra         <= n_ra;
        r_di         <= n_di;
        r_run        <= n_run;
        r_wa         <= n_wa;
        r_last       <= n_last;
        r_first      <= n_first;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
    end

    // Page map: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_wa] <= w_wd;
        end
        r_rd_data <= r_map[w_rd_addr];
    end

    // Output register holds a finished item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= cpa_pkg::OUT_DATA_W'({r_res_start, r_res_status});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/core/cpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page allocator port checker
// Watches the top-level ports for reset, busy and result-format rules.
// ----------------------------------------------------------------------------
module cpa_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [cpa_pkg::OUT_DATA_W-1:0]  i_m_tdata
);

    // The clearing pass keeps the request side closed after reset.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_s_tready)
        else $error("request side open right after reset");

    // One item at a time: the block is busy the cycle after it takes one.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("request taken while an item is in work");

    // Failed requests report a zero start offset (frees do too, but only failures are checked).
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata[cpa_pkg::STAT_W-1:0] != cpa_pkg::ST_OK)
            |-> (i_m_tdata[cpa_pkg::STAT_W +: cpa_pkg::ADDR_W] == '0))
        else $error("failed result carries a start offset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed");

endmodule

bind contiguous_page_allocator_top cpa_checker u_cpa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

// ===== verif/cpa_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page allocator reply checker
// Watches the request, result and configuration ports of the allocator. It
// keeps its own shadow of the page map and page count, predicts the reply of
// every accepted request and compares each accepted result against the
// oldest prediction.
// ----------------------------------------------------------------------------
module cpa_reply_checker #(
    parameter int PAGES      = 64,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cpa_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_req_valid,
    input  logic                           i_req_ready,
    // Request data: size_bytes[18:0], address[36:19], zero pad [39:37].
    input  logic [cpa_pkg::IN_DATA_W-1:0]  i_req_data,
    // Request user: kind.
    input  logic                           i_req_kind,
    input  logic                           i_rsp_valid,
    input  logic                           i_rsp_ready,
    // Result data: status[1:0], run_start[19:2], zero pad [23:20].
    input  logic [cpa_pkg::OUT_DATA_W-1:0] i_rsp_data,
    output int                             o_mismatches,
    output int                             o_outstanding,
    output int                             o_replies,
    output int                             o_grants
);

    typedef struct packed {
        cpa_pkg::t_status           status;
        logic [cpa_pkg::ADDR_W-1:0] start;
    } t_reply;

    localparam int REPORT_LIMIT = 10;

    // Shadow state of the allocator.
    logic [PAGES-1:0]          shadow_taken;
    logic [cpa_pkg::CFG_W-1:0] shadow_page_count;
    t_reply                    awaited_replies[$];

    int     mismatch_count;
    int     reply_count;
    int     grant_count;
    t_reply want;
    t_reply fresh;

    // Count one wrong or unexpected result; print it only for the first REPORT_LIMIT.
    task automatic note_mismatch(input string what, input t_reply exp_reply);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] result mismatch (%s): expected status %0d start 0x%05h",
                     $realtime, what, exp_reply.status, exp_reply.start);
            $display("    got status %0d start 0x%05h pad 0x%0h",
                     i_rsp_data[1:0], i_rsp_data[19:2], i_rsp_data[23:20]);
        end
    endtask

    // First-fit allocation or single-page free against the shadow map.
    task automatic serve_request(input logic kind,
                                 input logic [cpa_pkg::SIZE_W-1:0] size,
                                 input logic [cpa_pkg::ADDR_W-1:0] addr,
                                 output t_reply reply);
        int unsigned managed;
        int unsigned need;
        int unsigned run_len;
        int unsigned first_page;
        int unsigned page;
        bit          found;
        managed = (shadow_page_count > PAGES) ? PAGES : shadow_page_count;
        reply.status = cpa_pkg::ST_OK;
        reply.start  = '0;
        found = 1'b0;
        if (kind == cpa_pkg::KIND_ALLOC) begin
            if (size == '0) begin
                reply.status = cpa_pkg::ST_BAD_SIZE;
            end else begin
                need = (int'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
                run_len = 0;
                reply.status = cpa_pkg::ST_NO_RUN;
                for (int i = 0; i < managed && !found; i++) begin
                    run_len = shadow_taken[i] ? 0 : run_len + 1;
                    if (run_len == need) begin
                        found = 1'b1;
                        first_page = i + 1 - need;
                        for (int j = first_page; j <= i; j++) begin
                            shadow_taken[j] = 1'b1;
                        end
                        reply.status = cpa_pkg::ST_OK;
                        reply.start  = cpa_pkg::ADDR_W'(first_page * PAGE_BYTES);
                    end
                end
            end
        end else begin
            page = int'(addr) / PAGE_BYTES;
            if (page >= managed) begin
                reply.status = cpa_pkg::ST_BAD_ADDR;
            end else begin
                shadow_taken[page] = 1'b0;
            end
        end
    endtask

    // Track configuration, predict on each request, check on each result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_taken      = '0;
            shadow_page_count = cpa_pkg::CFG_RESET;
            awaited_replies.delete();
            mismatch_count    = 0;
            reply_count       = 0;
            grant_count       = 0;
        end else begin
            if (i_cfg_we) begin
                shadow_page_count = i_cfg_wdata;
            end
            if (i_rsp_valid && i_rsp_ready) begin
                reply_count++;
                if (awaited_replies.size() == 0) begin
                    want = '0;
                    note_mismatch("no request waiting", want);
                end else begin
                    want = awaited_replies.pop_front();
                    if (want.status == cpa_pkg::ST_OK && want.start != '0) begin
                        grant_count++;
                    end
                    if (i_rsp_data[1:0] != want.status) begin
                        note_mismatch("status", want);
                    end else if (i_rsp_data[19:2] != want.start) begin
                        note_mismatch("run start", want);
                    end else if (i_rsp_data[23:20] != '0) begin
                        note_mismatch("pad bits", want);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                serve_request(i_req_kind, i_req_data[18:0], i_req_data[36:19], fresh);
                awaited_replies.push_back(fresh);
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= awaited_replies.size();
        o_replies     <= reply_count;
        o_grants      <= grant_count;
    end

endmodule

// ===== verif/tb_contiguous_page_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page allocator testbench
// Drives allocate and free requests through the stream ports under several
// page counts and handshake idling mixes. A directed opening covers zero
// size, exact and rounded sizes, a full map, oversize runs, frees of free
// pages and out-of-range frees; random traffic follows. The reply checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_contiguous_page_allocator_top;

    localparam int PAGES          = 64;
    localparam int PAGE_BYTES     = 4096;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 150;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [cpa_pkg::CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [cpa_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                           s_axis_tuser  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [cpa_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int replies;
    int grants;

    int          send_idle_pct = 10;
    int          recv_idle_pct = 45;
    int          requests_sent = 0;
    int          settings_written = 0;
    int          quiet_cycles = 0;
    int unsigned page_limit = cpa_pkg::CFG_RESET;

    logic [cpa_pkg::CFG_W-1:0] cfg_plan [PHASES] = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd5,
                                                     7'd16, 7'd0, 7'd33, 7'd63, 7'd100,
                                                     7'd64, 7'd24};

    always #2 i_clk = ~i_clk;

    contiguous_page_allocator_top #(
        .PAGES      (PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cpa_reply_checker #(
        .PAGES      (PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_kind    (s_axis_tuser),
        .i_rsp_valid   (m_axis_tvalid),
        .i_rsp_ready   (m_axis_tready),
        .i_rsp_data    (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_replies     (replies),
        .o_grants      (grants)
    );

    // Result side back-pressure.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog on cycles in which no item moves.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("contiguous_page_allocator_top verification failed");
            $finish;
        end
    end

    // Offer one request, with optional idle cycles first, and hold it until taken.
    task automatic send_request(input logic kind, input logic [cpa_pkg::SIZE_W-1:0] size,
                                input logic [cpa_pkg::ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, addr, size};
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    // Let every reply drain, then write a new page count.
    task automatic reconfigure(input logic [cpa_pkg::CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        page_limit = value;
        settings_written++;
    endtask

    function automatic int unsigned managed_pages();
        return (page_limit > PAGES) ? PAGES : page_limit;
    endfunction

    // Free every managed page so the next stretch starts from an open map.
    task automatic sweep_free();
        for (int p = 0; p < managed_pages(); p++) begin
            send_request(cpa_pkg::KIND_FREE, cpa_pkg::SIZE_W'($urandom),
                         cpa_pkg::ADDR_W'(p * PAGE_BYTES +
                                          $urandom_range(0, PAGE_BYTES - 1)));
        end
    endtask

    // One random request, mostly well-formed for the current page count.
    task automatic send_random();
        logic [cpa_pkg::SIZE_W-1:0] size;
        logic [cpa_pkg::ADDR_W-1:0] addr;
        int unsigned                pick;
        size = cpa_pkg::SIZE_W'($urandom);
        addr = cpa_pkg::ADDR_W'($urandom);
        if ($urandom_range(0, 99) < 55) begin
            if (managed_pages() > 0 && $urandom_range(0, 9) != 0) begin
                addr = cpa_pkg::ADDR_W'($urandom_range(0, managed_pages() - 1) * PAGE_BYTES +
                                        $urandom_range(0, PAGE_BYTES - 1));
            end
            send_request(cpa_pkg::KIND_FREE, size, addr);
        end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                size = '0;
            end else if (pick < 6) begin
                size = cpa_pkg::SIZE_W'($urandom_range(1, 8) * PAGE_BYTES);
            end else if (pick >= 8) begin
                size = cpa_pkg::SIZE_W'($urandom_range(1, 3 * PAGE_BYTES));
            end
            send_request(cpa_pkg::KIND_ALLOC, size, addr);
        end
    endtask

    initial begin : stimulus
        int phase_start;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset page count.
        send_request(cpa_pkg::KIND_ALLOC, '0, cpa_pkg::ADDR_W'($urandom));
        send_request(cpa_pkg::KIND_ALLOC, 19'd1, cpa_pkg::ADDR_W'($urandom));
        send_request(cpa_pkg::KIND_ALLOC, cpa_pkg::SIZE_W'(PAGE_BYTES),
                     cpa_pkg::ADDR_W'($urandom));
        send_request(cpa_pkg::KIND_ALLOC, cpa_pkg::SIZE_W'(PAGE_BYTES + 1),
                     cpa_pkg::ADDR_W'($urandom));
        send_request(cpa_pkg::KIND_FREE, cpa_pkg::SIZE_W'($urandom),
                     cpa_pkg::ADDR_W'(PAGE_BYTES + 123));
        // Free of a page that is already free.
        send_request(cpa_pkg::KIND_FREE, cpa_pkg::SIZE_W'($urandom),
                     cpa_pkg::ADDR_W'(PAGE_BYTES));
        send_request(cpa_pkg::KIND_ALLOC, cpa_pkg::SIZE_W'(PAGE_BYTES / 2),
                     cpa_pkg::ADDR_W'($urandom));
        send_request(cpa_pkg::KIND_ALLOC, cpa_pkg::SIZE_W'(PAGES * PAGE_BYTES),
                     cpa_pkg::ADDR_W'($urandom));
        // Run longer than the managed pages.
        send_request(cpa_pkg::KIND_ALLOC, '1, cpa_pkg::ADDR_W'($urandom));
        send_request(cpa_pkg::KIND_ALLOC, cpa_pkg::SIZE_W'(60 * PAGE_BYTES),
                     cpa_pkg::ADDR_W'($urandom));
        send_request(cpa_pkg::KIND_ALLOC, 19'd1, '1);
        send_request(cpa_pkg::KIND_FREE, '1, '1);
        send_request(cpa_pkg::KIND_ALLOC, 19'd1, '0);

        // Shrunk page count: pages above it are out of range but kept.
        reconfigure(7'd16);
        send_request(cpa_pkg::KIND_FREE, '0, cpa_pkg::ADDR_W'(20 * PAGE_BYTES));
        send_request(cpa_pkg::KIND_FREE, '0, '0);
        send_request(cpa_pkg::KIND_ALLOC, cpa_pkg::SIZE_W'(16 * PAGE_BYTES), '0);

        // No managed pages at all.
        reconfigure(7'd0);
        send_request(cpa_pkg::KIND_ALLOC, 19'd1, '0);
        send_request(cpa_pkg::KIND_FREE, '0, '0);

        // Page count above the map size acts as the full map.
        reconfigure(7'd127);
        send_request(cpa_pkg::KIND_FREE, '0, cpa_pkg::ADDR_W'(63 * PAGE_BYTES));
        send_request(cpa_pkg::KIND_ALLOC, cpa_pkg::SIZE_W'(PAGE_BYTES), '0);

        // Single managed page.
        reconfigure(7'd1);
        send_request(cpa_pkg::KIND_ALLOC, cpa_pkg::SIZE_W'(2 * PAGE_BYTES), '0);
        send_request(cpa_pkg::KIND_FREE, '0, cpa_pkg::ADDR_W'(PAGE_BYTES - 1));
        send_request(cpa_pkg::KIND_ALLOC, cpa_pkg::SIZE_W'(PAGE_BYTES), '0);

        // Random phases over page counts and idling mixes.
        for (int ph = 0; ph < PHASES; ph++) begin
            reconfigure(cfg_plan[ph]);
            if (ph < PHASES / 3) begin
                send_idle_pct = 10;
                recv_idle_pct = 45;
            end else if (ph < 2 * PHASES / 3) begin
                send_idle_pct = 45;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            phase_start = requests_sent;
            sweep_free();
            while (requests_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) == 0) begin
                    sweep_free();
                end else begin
                    send_random();
                end
            end
        end

        // Drain and let the block settle.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests under %0d page-count writes and three idling mixes.",
                 requests_sent, settings_written);
        $display("Checked %0d replies, %0d of them allocations away from page zero.",
                 replies, grants);
        if (mismatches == 0 && outstanding == 0) begin
            $display("contiguous_page_allocator_top verification clean");
        end else begin
            $display("Mismatches: %0d, replies still awaited: %0d.", mismatches, outstanding);
            $display("contiguous_page_allocator_top verification failed");
        end
        $finish;
    end

endmodule
